// ===== rtl/aau_pkg.sv =====
// Shared types, codes and constants of the accumulator arithmetic unit.
package aau_pkg;

   localparam int AAU_MAX_POWER_STEPS = 255;
   localparam int AAU_FRAC_BITS       = 16;

   localparam logic [31:0] AAU_S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] AAU_S32_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_POW = 3'd4
   } aau_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_PROD,
      ST_MUL_SAT,
      ST_DIV_RUN,
      ST_DIV_SAT,
      ST_FINISH
   } aau_state_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] operand;
   } aau_req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               overflow;
      logic               div_zero;
   } aau_rsp_type;

   typedef struct packed {
      logic load;
      logic mul_prod;
      logic mul_sat;
      logic div_step;
      logic div_sat;
      logic out_load;
   } aau_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic opd_zero;
   } aau_status_type;

endpackage

// ===== rtl/aau_ctrl.sv =====
// Sequencing state machine of the accumulator arithmetic unit.
module aau_ctrl import aau_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [2:0]     req_op,
   input  logic           rsp_stall,
   input  aau_status_type status,
   output logic           req_stall,
   output logic           rsp_valid,
   output aau_cmd_type    cmd
);

   aau_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op) inside
                  OP_MUL, OP_POW: state_in = ST_MUL_PROD;
                  OP_DIV:         state_in = status.opd_zero ? ST_FINISH : ST_DIV_RUN;
                  default:        state_in = ST_FINISH;
               endcase
            end
         end
         ST_MUL_PROD: state_in = status.cnt_zero ? ST_FINISH : ST_MUL_SAT;
         ST_MUL_SAT:  state_in = ST_MUL_PROD;
         ST_DIV_RUN:  state_in = status.cnt_zero ? ST_DIV_SAT : ST_DIV_RUN;
         ST_DIV_SAT:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_MUL_PROD: cmd.mul_prod = !status.cnt_zero;
         ST_MUL_SAT:  cmd.mul_sat  = 1'b1;
         ST_DIV_RUN:  cmd.div_step = !status.cnt_zero;
         ST_DIV_SAT:  cmd.div_sat  = 1'b1;
         ST_FINISH:   cmd.out_load = out_free;
         default:     cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/aau_datapath.sv =====
// Accumulator, multiplier, serial divider and result register.
module aau_datapath import aau_pkg::*; #(
   parameter int MAX_POWER_STEPS = AAU_MAX_POWER_STEPS,
   parameter int FRAC_BITS       = AAU_FRAC_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  aau_req_type    req_data,
   input  aau_cmd_type    cmd,
   output aau_status_type status,
   output aau_rsp_type    rsp_data
);

   localparam int NUM_W   = 32 + FRAC_BITS;
   localparam int PCNT_W  = $clog2(MAX_POWER_STEPS + 1);
   localparam int DCNT_W  = $clog2(NUM_W + 1);
   localparam int CNT_W   = (PCNT_W > DCNT_W) ? PCNT_W : DCNT_W;
   localparam logic [31:0] ONE_FX    = 32'(1) << FRAC_BITS;
   localparam logic [31:0] MAX_STEPS = 32'(MAX_POWER_STEPS);

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // {saturated, value}
   function automatic logic [32:0] sat_signed(input logic [63:0] mag, input logic neg);
      logic [32:0] res;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) res = {1'b1, AAU_S32_MIN};
         else                               res = {1'b0, ~mag[31:0] + 32'd1};
      end else begin
         if (mag > 64'h0000_0000_7FFF_FFFF) res = {1'b1, AAU_S32_MAX};
         else                               res = {1'b0, mag[31:0]};
      end
      return res;
   endfunction

   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      r_ff, r_in;
   logic [31:0]      mfac_ff, mfac_in;
   logic [63:0]      prod_ff, prod_in;
   logic             neg_ff, neg_in;
   logic [31:0]      rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ov_ff, ov_in;
   logic             dz_ff, dz_in;
   aau_rsp_type      rsp_ff, rsp_in;

   logic [31:0]      opd;
   logic [32:0]      sum_w;
   logic [63:0]      prod_w;
   logic [32:0]      mul_res;
   logic [32:0]      div_res;
   logic [32:0]      rem_sh;
   logic [32:0]      rem_diff;
   logic             q_bit;
   logic [31:0]      n_full;
   logic [CNT_W-1:0] pow_cnt;

   assign opd = req_data.operand;

   always_comb begin
      if (req_data.op == OP_SUB) sum_w = {acc_ff[31], acc_ff} - {opd[31], opd};
      else                       sum_w = {acc_ff[31], acc_ff} + {opd[31], opd};
   end

   assign prod_w  = {32'd0, mag32(r_ff)} * {32'd0, mag32(mfac_ff)};
   assign mul_res = sat_signed(prod_ff >> FRAC_BITS, neg_ff);
   assign div_res = sat_signed(64'(quo_ff), neg_ff);

   // restoring divide, one quotient bit per cycle
   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, mfac_ff};
   assign q_bit    = (rem_sh >= {1'b0, mfac_ff});

   // steps = ceil(e) - 1 for e above one, clamped
   assign n_full = (opd - 32'd1) >> FRAC_BITS;
   always_comb begin
      if (opd[31] || (opd <= ONE_FX)) pow_cnt = '0;
      else if (n_full > MAX_STEPS)    pow_cnt = CNT_W'(MAX_POWER_STEPS);
      else                            pow_cnt = CNT_W'(n_full);
   end

   always_comb begin
      acc_in  = acc_ff;
      r_in    = r_ff;
      mfac_in = mfac_ff;
      prod_in = prod_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      ov_in   = ov_ff;
      dz_in   = dz_ff;
      rsp_in  = rsp_ff;

      if (cmd.load) begin
         ov_in = 1'b0;
         dz_in = 1'b0;
         r_in  = acc_ff;
         unique case (req_data.op) inside
            OP_ADD, OP_SUB: begin
               if (sum_w[32] != sum_w[31]) begin
                  ov_in = 1'b1;
                  r_in  = sum_w[32] ? AAU_S32_MIN : AAU_S32_MAX;
               end else begin
                  r_in  = sum_w[31:0];
               end
            end
            OP_MUL: begin
               mfac_in = opd;
               cnt_in  = CNT_W'(1);
            end
            OP_DIV: begin
               if (opd == '0) begin
                  dz_in = 1'b1;
                  if (acc_ff == '0)   r_in = '0;
                  else if (acc_ff[31]) r_in = AAU_S32_MIN;
                  else                r_in = AAU_S32_MAX;
               end else begin
                  num_in  = NUM_W'(mag32(acc_ff)) << FRAC_BITS;
                  mfac_in = mag32(opd);
                  rem_in  = '0;
                  quo_in  = '0;
                  neg_in  = acc_ff[31] ^ opd[31];
                  cnt_in  = CNT_W'(NUM_W);
               end
            end
            OP_POW: begin
               mfac_in = acc_ff;
               cnt_in  = pow_cnt;
            end
            default: r_in = acc_ff;
         endcase
      end

      if (cmd.mul_prod) begin
         prod_in = prod_w;
         neg_in  = r_ff[31] ^ mfac_ff[31];
      end

      if (cmd.mul_sat) begin
         r_in   = mul_res[31:0];
         ov_in  = ov_ff | mul_res[32];
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (cmd.div_step) begin
         rem_in = q_bit ? rem_diff[31:0] : rem_sh[31:0];
         quo_in = {quo_ff[NUM_W-2:0], q_bit};
         num_in = num_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (cmd.div_sat) begin
         r_in  = div_res[31:0];
         ov_in = ov_ff | div_res[32];
      end

      if (cmd.out_load) begin
         acc_in          = r_ff;
         rsp_in.result   = r_ff;
         rsp_in.overflow = ov_ff;
         rsp_in.div_zero = dz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      mfac_ff <= mfac_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      ov_ff   <= ov_in;
      dz_ff   <= dz_in;
      rsp_ff  <= rsp_in;
   end

   assign status.cnt_zero = (cnt_ff == '0);
   assign status.opd_zero = (opd == '0);
   assign rsp_data        = rsp_ff;

endmodule

// ===== rtl/accumulator_arith_unit.sv =====
// Add, subtract, unused codes and a zero divisor finish without a multiply or divide step;
// power runs a multiply and saturate step per clamped step (multiply runs one), and divide runs
// the serial divider, one quotient bit per cycle, before its saturate step.
// One item at a time: the next input transfer is taken the cycle after the result register loads.
// Synchronous active-high reset clears the accumulator to zero and empties the result register.
// Top level: ties the sequencer to the accumulator datapath.
module accumulator_arith_unit import aau_pkg::*; #(
   parameter int MAX_POWER_STEPS = AAU_MAX_POWER_STEPS,
   parameter int FRAC_BITS       = AAU_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // input channel: operation and operand
   input  logic        req_valid,
   output logic        req_stall,
   input  aau_req_type req_data,
   // result channel: new accumulator value and flags
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output aau_rsp_type rsp_data
);

   aau_cmd_type    cmd;
   aau_status_type status;

   // Sequencer: picks the path per operation, steps multiply and divide until the datapath's counter
   // reaches zero and holds a finished item until the result register is free.
   aau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Datapath: accumulator, 32x32 magnitude multiplier with a registered product,
   // restoring divider and saturation; the accumulator is written when the result loads.
   aau_datapath #(
      .MAX_POWER_STEPS (MAX_POWER_STEPS),
      .FRAC_BITS       (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/aau_checker.sv =====
// Port-level checks of the accumulator arithmetic unit and their bind.
module aau_checker import aau_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input aau_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input aau_rsp_type rsp_data
);

   // one item in flight: a transfer in closes the input side
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after a transfer");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // divide by zero never reports saturation as well
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.overflow && rsp_data.div_zero))
      else $error("overflow and div_zero both set");

   // divide by zero yields zero or a signed limit
   a_div_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_zero) |->
         (rsp_data.result == '0 || rsp_data.result == AAU_S32_MAX ||
          rsp_data.result == AAU_S32_MIN))
      else $error("bad divide-by-zero result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind accumulator_arith_unit aau_checker u_aau_checker (.*);
